FILE: src/mhpq_pkg.sv
// shared constants and types of the min-heap priority queue
package mhpq_pkg;

	localparam int DEPTH    = 1024;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int KEY_BITS = 32;
	localparam int TAG_BITS = 32;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// one heap entry
	typedef struct packed {
		logic signed [KEY_BITS-1:0] key;
		logic        [TAG_BITS-1:0] tag;
	} entry_t;

	// datapath command, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_PUSH,
		OP_REJECT,
		OP_LOAD_POP,
		OP_GRAB,
		OP_RD_UP,
		OP_UP_MOVE,
		OP_RD_DN,
		OP_DN_MOVE,
		OP_PLACE,
		OP_RESULT
	} op_t;

	// datapath status toward the controller
	typedef struct packed {
		logic room;
		logic heap_empty;
		logic pos_zero;
		logic lc_in;
		logic up_less;
		logic dn_less;
	} stat_t;

endpackage

FILE: src/min_heap_priority_queue.sv
// top level of the binary min-heap priority queue
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    mode, push_key, push_tag
//  out      out  out_valid/out_ready  accepted, popped_key, popped_tag, entry_count,
//                                     head_valid, head_key, head_tag
//  cfg      in   cfg_we               cfg_wdata (capacity_limit)
//
// one item at a time: a new input is taken only after the previous result is registered;
// a rejected item goes straight to the result, a pop that empties the heap skips the sift,
// a push reads and compares its parent per level climbed toward the root, and a pop reads
// and compares the children per level descended toward a leaf.
// a finished result waits in the output register while the next item is taken; the next
// result stalls until it leaves. reset clears count, capacity 1024, memory not cleared
module min_heap_priority_queue
	import mhpq_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CNT_W-1:0]           cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic signed [KEY_BITS-1:0] push_key,
	input  logic [TAG_BITS-1:0]        push_tag,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       accepted,
	output logic signed [KEY_BITS-1:0] popped_key,
	output logic [TAG_BITS-1:0]        popped_tag,
	output logic [CNT_W-1:0]           entry_count,
	output logic                       head_valid,
	output logic signed [KEY_BITS-1:0] head_key,
	output logic [TAG_BITS-1:0]        head_tag
);

	op_t   op;
	stat_t stat;

	// sequencer
	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.op        (op)
	);

	// storage and datapath
	mhpq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.push_key    (push_key),
		.push_tag    (push_tag),
		.op          (op),
		.stat        (stat),
		.accepted    (accepted),
		.popped_key  (popped_key),
		.popped_tag  (popped_tag),
		.entry_count (entry_count),
		.head_valid  (head_valid),
		.head_key    (head_key),
		.head_tag    (head_tag)
	);

endmodule

FILE: src/mhpq_datapath.sv
// heap storage, position and count registers, compares and result registers
module mhpq_datapath
	import mhpq_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CNT_W-1:0]           cfg_wdata,
	input  logic signed [KEY_BITS-1:0] push_key,
	input  logic [TAG_BITS-1:0]        push_tag,
	input  op_t                        op,
	output stat_t                      stat,
	output logic                       accepted,
	output logic signed [KEY_BITS-1:0] popped_key,
	output logic [TAG_BITS-1:0]        popped_tag,
	output logic [CNT_W-1:0]           entry_count,
	output logic                       head_valid,
	output logic signed [KEY_BITS-1:0] head_key,
	output logic [TAG_BITS-1:0]        head_tag
);

	entry_t            mem [DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	logic [ADDR_W-1:0] pos_q;
	entry_t            ent_q;
	entry_t            head_q;
	entry_t            rdata_a_q;
	entry_t            rdata_b_q;
	logic              acc_q;
	entry_t            pop_q;
	logic              res_acc_q;
	entry_t            res_pop_q;
	logic [CNT_W-1:0]  res_count_q;
	logic              res_head_valid_q;
	entry_t            res_head_q;

	logic [CNT_W-1:0]  cap_eff;
	logic [CNT_W:0]    lc;
	logic [CNT_W:0]    rc;
	logic              rc_in;
	logic [ADDR_W-1:0] parent;
	logic [ADDR_W-1:0] last;
	logic              pick_right;
	entry_t            pick;
	logic [ADDR_W-1:0] pick_idx;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	logic              rd_en;
	logic              wr_en;
	entry_t            wdata;

	// tree arithmetic around the current position
	assign cap_eff    = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
	assign lc         = {1'b0, pos_q, 1'b1};
	assign rc         = lc + (CNT_W+1)'(1);
	assign rc_in      = rc < {1'b0, count_q};
	assign parent     = (pos_q - ADDR_W'(1)) >> 1;
	assign last       = ADDR_W'(count_q - CNT_W'(1));

	// child pick, right only when strictly smaller
	assign pick_right = rc_in && ($signed(rdata_b_q.key) < $signed(rdata_a_q.key));
	assign pick       = pick_right ? rdata_b_q : rdata_a_q;
	assign pick_idx   = pick_right ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

	// status
	assign stat.room       = count_q < cap_eff;
	assign stat.heap_empty = (count_q == '0);
	assign stat.pos_zero   = (pos_q == '0);
	assign stat.lc_in      = lc < {1'b0, count_q};
	assign stat.up_less    = $signed(ent_q.key) < $signed(rdata_a_q.key);
	assign stat.dn_less    = $signed(pick.key) < $signed(ent_q.key);

	// read address and write data selection
	always_comb begin
		raddr_a = lc[ADDR_W-1:0];
		raddr_b = rc[ADDR_W-1:0];
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wdata   = ent_q;
		case (op)
			OP_LOAD_POP: begin
				raddr_a = last;
				rd_en   = 1'b1;
			end
			OP_RD_UP: begin
				raddr_a = parent;
				rd_en   = 1'b1;
			end
			OP_RD_DN: begin
				rd_en = 1'b1;
			end
			OP_UP_MOVE: begin
				wr_en = 1'b1;
				wdata = rdata_a_q;
			end
			OP_DN_MOVE: begin
				wr_en = 1'b1;
				wdata = pick;
			end
			OP_PLACE: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// heap memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wdata;
		end
		if (rd_en) begin
			rdata_a_q <= mem[raddr_a];
			rdata_b_q <= mem[raddr_b];
		end
	end

	// count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CNT_W'(DEPTH);
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (op)
				OP_LOAD_PUSH: count_q <= count_q + CNT_W'(1);
				OP_LOAD_POP:  count_q <= count_q - CNT_W'(1);
				default:      count_q <= count_q;
			endcase
		end
	end

	// moving entry, position, root copy and result
	always_ff @(posedge clk) begin
		if (wr_en && (pos_q == '0)) begin
			head_q <= wdata;
		end
		case (op)
			OP_LOAD_PUSH: begin
				ent_q <= '{key: push_key, tag: push_tag};
				pos_q <= count_q[ADDR_W-1:0];
				acc_q <= 1'b1;
				pop_q <= '0;
			end
			OP_REJECT: begin
				acc_q <= 1'b0;
				pop_q <= '0;
			end
			OP_LOAD_POP: begin
				acc_q <= 1'b1;
				pop_q <= head_q;
			end
			OP_GRAB: begin
				ent_q <= rdata_a_q;
				pos_q <= '0;
			end
			OP_UP_MOVE: begin
				pos_q <= parent;
			end
			OP_DN_MOVE: begin
				pos_q <= pick_idx;
			end
			OP_RESULT: begin
				res_acc_q        <= acc_q;
				res_pop_q        <= pop_q;
				res_count_q      <= count_q;
				res_head_valid_q <= (count_q != '0);
				res_head_q       <= (count_q != '0) ? head_q : '0;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign accepted    = res_acc_q;
	assign popped_key  = res_pop_q.key;
	assign popped_tag  = res_pop_q.tag;
	assign entry_count = res_count_q;
	assign head_valid  = res_head_valid_q;
	assign head_key    = res_head_q.key;
	assign head_tag    = res_head_q.tag;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");
	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, pos_q} < count_q))
		else $error("write outside occupied slots");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_LOAD_POP) |-> (count_q != '0))
		else $error("pop started on an empty heap");
`endif

endmodule

FILE: src/mhpq_ctrl.sv
// sequencer for push sift-up and pop sift-down
module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  mode,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output op_t   op
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_POP_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// command and next state
	always_comb begin
		op        = OP_NONE;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_PUSH) begin
						if (stat.room) begin
							op        = OP_LOAD_PUSH;
							state_nxt = S_UP_RD;
						end else begin
							op        = OP_REJECT;
							state_nxt = S_FIN;
						end
					end else begin
						if (!stat.heap_empty) begin
							op        = OP_LOAD_POP;
							state_nxt = S_POP_LOAD;
						end else begin
							op        = OP_REJECT;
							state_nxt = S_FIN;
						end
					end
				end
			end
			S_UP_RD: begin
				if (stat.pos_zero) begin
					op        = OP_PLACE;
					state_nxt = S_FIN;
				end else begin
					op        = OP_RD_UP;
					state_nxt = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_less) begin
					op        = OP_UP_MOVE;
					state_nxt = S_UP_RD;
				end else begin
					op        = OP_PLACE;
					state_nxt = S_FIN;
				end
			end
			S_POP_LOAD: begin
				if (stat.heap_empty) begin
					state_nxt = S_FIN;
				end else begin
					op        = OP_GRAB;
					state_nxt = S_DN_RD;
				end
			end
			S_DN_RD: begin
				if (!stat.lc_in) begin
					op        = OP_PLACE;
					state_nxt = S_FIN;
				end else begin
					op        = OP_RD_DN;
					state_nxt = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_less) begin
					op        = OP_DN_MOVE;
					state_nxt = S_DN_RD;
				end else begin
					op        = OP_PLACE;
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					op        = OP_RESULT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new item taken while one is in flight");
	a_fin_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not presented");
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before its transfer");
`endif

endmodule

FILE: test/mhpq_checker.sv
`timescale 1ns / 100ps
// checker of the min-heap priority queue: heap predictor and result comparison
module mhpq_checker
	import mhpq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                mode,
	input  logic [KEY_BITS-1:0] push_key,
	input  logic [TAG_BITS-1:0] push_tag,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                accepted,
	input  logic [KEY_BITS-1:0] popped_key,
	input  logic [TAG_BITS-1:0] popped_tag,
	input  logic [CNT_W-1:0]    entry_count,
	input  logic                head_valid,
	input  logic [KEY_BITS-1:0] head_key,
	input  logic [TAG_BITS-1:0] head_tag,
	output int                  error_count,
	output int                  open_count
);

	// one predicted result
	typedef struct packed {
		logic                ok;
		logic [KEY_BITS-1:0] pkey;
		logic [TAG_BITS-1:0] ptag;
		logic [CNT_W-1:0]    count;
		logic                hv;
		logic [KEY_BITS-1:0] hkey;
		logic [TAG_BITS-1:0] htag;
	} heap_result_t;

	// predicted heap contents
	logic signed [KEY_BITS-1:0] heap_key [DEPTH];
	logic        [TAG_BITS-1:0] heap_tag [DEPTH];
	int                         heap_fill;
	logic        [CNT_W-1:0]    capacity;

	heap_result_t due_results[$];

	initial begin
		error_count = 0;
		open_count  = 0;
		heap_fill   = 0;
		capacity    = CNT_W'(DEPTH);
	end

	function automatic void swap_entries(input int a, input int b);
		logic signed [KEY_BITS-1:0] k;
		logic        [TAG_BITS-1:0] t;
		k = heap_key[a];
		t = heap_tag[a];
		heap_key[a] = heap_key[b];
		heap_tag[a] = heap_tag[b];
		heap_key[b] = k;
		heap_tag[b] = t;
	endfunction

	// apply one operation to the predicted heap and return its result
	function automatic heap_result_t heap_apply(input logic op, input logic [KEY_BITS-1:0] k,
			input logic [TAG_BITS-1:0] t);
		heap_result_t r;
		int pos, up, lc, rc, pick, room;
		bit done;
		r = '0;
		room = (capacity > DEPTH) ? DEPTH : int'(capacity);
		if (op == MODE_PUSH) begin
			if (heap_fill < room) begin
				heap_key[heap_fill] = k;
				heap_tag[heap_fill] = t;
				pos = heap_fill;
				heap_fill++;
				// climb while the parent key is strictly greater
				done = 1'b0;
				while (pos > 0 && !done) begin
					up = (pos - 1) / 2;
					if (heap_key[pos] < heap_key[up]) begin
						swap_entries(pos, up);
						pos = up;
					end else begin
						done = 1'b1;
					end
				end
				r.ok = 1'b1;
			end
		end else if (heap_fill > 0) begin
			r.ok   = 1'b1;
			r.pkey = heap_key[0];
			r.ptag = heap_tag[0];
			heap_fill--;
			heap_key[0] = heap_key[heap_fill];
			heap_tag[0] = heap_tag[heap_fill];
			// descend, right child only when strictly smaller than the left
			pos  = 0;
			done = 1'b0;
			while (!done) begin
				lc = 2 * pos + 1;
				rc = 2 * pos + 2;
				if (lc >= heap_fill) begin
					done = 1'b1;
				end else begin
					pick = lc;
					if (rc < heap_fill && heap_key[rc] < heap_key[lc])
						pick = rc;
					if (heap_key[pick] < heap_key[pos]) begin
						swap_entries(pos, pick);
						pos = pick;
					end else begin
						done = 1'b1;
					end
				end
			end
		end
		r.count = CNT_W'(heap_fill);
		r.hv    = heap_fill > 0;
		if (heap_fill > 0) begin
			r.hkey = heap_key[0];
			r.htag = heap_tag[0];
		end
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
			error_count++;
		end
	endfunction

	// watch config, input and output transfers
	always @(posedge clk or negedge arst_n) begin
		heap_result_t want;
		if (!arst_n) begin
			heap_fill = 0;
			capacity  = CNT_W'(DEPTH);
			due_results.delete();
			open_count = 0;
		end else begin
			if (cfg_we)
				capacity = cfg_wdata;
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, got count %h",
						$time, entry_count);
					error_count++;
				end else begin
					want = due_results.pop_front();
					check_field("accepted", want.ok, accepted);
					check_field("popped_key", want.pkey, popped_key);
					check_field("popped_tag", want.ptag, popped_tag);
					check_field("entry_count", want.count, entry_count);
					check_field("head_valid", want.hv, head_valid);
					check_field("head_key", want.hkey, head_key);
					check_field("head_tag", want.htag, head_tag);
				end
			end
			if (in_valid && in_ready)
				due_results.push_back(heap_apply(mode, push_key, push_tag));
			open_count = due_results.size();
		end
	end

endmodule

FILE: test/tb_min_heap_priority_queue.sv
`timescale 1ns / 100ps
// testbench top of the min-heap priority queue: stimulus, timeout and verdict
module tb_min_heap_priority_queue
	import mhpq_pkg::*;
;

	localparam int RUN_LIMIT = 1500000;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [CNT_W-1:0]           cfg_wdata = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic                       mode      = MODE_PUSH;
	logic signed [KEY_BITS-1:0] push_key  = '0;
	logic [TAG_BITS-1:0]        push_tag  = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       accepted;
	logic signed [KEY_BITS-1:0] popped_key;
	logic [TAG_BITS-1:0]        popped_tag;
	logic [CNT_W-1:0]           entry_count;
	logic                       head_valid;
	logic signed [KEY_BITS-1:0] head_key;
	logic [TAG_BITS-1:0]        head_tag;

	int error_count;
	int open_count;
	int cycle_count = 0;
	bit calm = 1'b0;

	min_heap_priority_queue i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.push_key    (push_key),
		.push_tag    (push_tag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accepted    (accepted),
		.popped_key  (popped_key),
		.popped_tag  (popped_tag),
		.entry_count (entry_count),
		.head_valid  (head_valid),
		.head_key    (head_key),
		.head_tag    (head_tag)
	);

	mhpq_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.push_key    (push_key),
		.push_tag    (push_tag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accepted    (accepted),
		.popped_key  (popped_key),
		.popped_tag  (popped_tag),
		.entry_count (entry_count),
		.head_valid  (head_valid),
		.head_key    (head_key),
		.head_tag    (head_tag),
		.error_count (error_count),
		.open_count  (open_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("tb_min_heap_priority_queue: done, errors");
			$finish;
		end
	end

	// receiver stalls about 30 percent of the time unless calm
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 30);
	end

	// mostly small keys so that ties are common, plus extremes and full range
	function automatic logic [KEY_BITS-1:0] pick_key();
		case ($urandom_range(3))
			0, 1: return $urandom_range(8) - 4;
			2: return $urandom();
			default: begin
				case ($urandom_range(3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
		endcase
	endfunction

	// one input transfer with random gaps in front
	task automatic send_item(input logic op, input logic [KEY_BITS-1:0] k,
			input logic [TAG_BITS-1:0] t);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		push_key <= k;
		push_tag <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold off the sender until every result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (open_count != 0) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int count, input int push_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(39) == 0)
				wait_drained();
			send_item(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP,
				pick_key(), $urandom());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty pop, extremes, equal keys and tie breaking
		send_item(MODE_POP, '0, '0);
		send_item(MODE_PUSH, 32'd5, 32'h0000_0001);
		send_item(MODE_PUSH, 32'd5, 32'h0000_0002);
		send_item(MODE_PUSH, 32'd3, 32'h0000_00a0);
		send_item(MODE_PUSH, 32'd3, 32'h0000_00b0);
		send_item(MODE_PUSH, 32'h7fff_ffff, 32'hffff_ffff);
		send_item(MODE_PUSH, 32'h8000_0000, 32'h0000_0000);
		send_item(MODE_PUSH, 32'hffff_ffff, 32'h5555_5555);
		send_item(MODE_PUSH, 32'h0000_0000, 32'haaaa_aaaa);
		repeat (6) send_item(MODE_POP, $urandom(), $urandom());
		send_item(MODE_PUSH, 32'd3, 32'h0000_00c0);
		repeat (2) send_item(MODE_POP, '0, '0);

		// capacity zero with an entry still held, then small capacities
		write_capacity(CNT_W'(0));
		random_phase(40, 60);
		write_capacity(CNT_W'(1));
		random_phase(50, 60);
		write_capacity(CNT_W'(2));
		random_phase(50, 55);
		write_capacity(CNT_W'(3));
		random_phase(60, 65);
		write_capacity(CNT_W'(7));
		random_phase(60, 70);
		write_capacity(CNT_W'(20));
		random_phase(80, 70);

		// long stretch with no random sender gaps and no receiver stalls
		calm = 1'b1;
		write_capacity(CNT_W'(100));
		random_phase(150, 60);
		calm = 1'b0;

		write_capacity(CNT_W'($urandom_range(30, 200)));
		random_phase(60, 45);
		write_capacity(CNT_W'(1025));
		random_phase(60, 40);
		write_capacity(CNT_W'(DEPTH));
		random_phase(50, 30);

		// capacity field at its top value, above depth
		write_capacity(11'h7ff);
		random_phase(40, 50);

		wait_drained();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("tb_min_heap_priority_queue: done, clean");
		else
			$display("tb_min_heap_priority_queue: done, errors");
		$finish;
	end

endmodule
